/* rtl/svsl_pkg.sv */
// Shared types, constants and helper functions of the sparse vector subset lookup unit.
`timescale 1ns / 1ps
package svsl_pkg;

  // Width of the vector_length register and of a tri-state value.
  localparam int LEN_W = 21;
  localparam int VAL_W = 2;

  // Tri-state value codes.
  localparam logic [VAL_W-1:0] VAL_FALSE   = 2'd0;
  localparam logic [VAL_W-1:0] VAL_TRUE    = 2'd1;
  localparam logic [VAL_W-1:0] VAL_MISSING = 2'd2;
  localparam logic [VAL_W-1:0] VAL_UNUSED  = 2'd3;

  // Item function codes.
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_VECTOR_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_VALUE = 1'b1;

  // Classification of one item, passed from the front end to the back end.
  typedef struct packed {
    logic is_load;        // table load rather than a query
    logic restart;        // begins a new load or a new query run
    logic force_missing;  // query answered as missing without a search
  } cls_t;

  localparam int CLS_W = $bits(cls_t);

  // The unused code 3 reads as missing.
  function automatic logic [VAL_W-1:0] norm_value(input logic [VAL_W-1:0] v);
    norm_value = (v == VAL_UNUSED) ? VAL_MISSING : v;
  endfunction

endpackage

/* rtl/svsl_if.sv */
// Channel interfaces: input items, result items and configuration writes.
`timescale 1ns / 1ps
interface svsl_in_if #(parameter int POSITION_BITS = 21);
  logic                     valid;
  logic                     ready;
  logic                     func;
  logic                     begin_req;
  logic [POSITION_BITS-1:0] entry_position;
  logic [1:0]               entry_value;
  logic [POSITION_BITS-1:0] query_index;
  logic                     query_missing;

  modport source (output valid, func, begin_req, entry_position, entry_value, query_index,
                  query_missing, input ready);
  modport sink (input valid, func, begin_req, entry_position, entry_value, query_index,
                query_missing, output ready);
endinterface

interface svsl_out_if #(parameter int POSITION_BITS = 21);
  logic                     valid;
  logic                     ready;
  logic [1:0]               element_value;
  logic                     emit;
  logic [POSITION_BITS-1:0] subset_position;
  logic [POSITION_BITS-1:0] hit_count;

  modport source (output valid, element_value, emit, subset_position, hit_count,
                  input ready);
  modport sink (input valid, element_value, emit, subset_position, hit_count,
                output ready);
endinterface

interface svsl_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [20:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/svsl_front.sv */
// Front end: accepts items, classifies them and numbers the queries of a run.
`timescale 1ns / 1ps
module svsl_front #(
  parameter int POSITION_BITS = 21
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  svsl_in_if.sink                        in_i,
  input  logic [svsl_pkg::LEN_W-1:0]     vector_length_i,
  output logic                           push_valid_o,
  input  logic                           push_ready_i,
  output svsl_pkg::cls_t                 cls_o,
  output logic [POSITION_BITS-1:0]       key_o,
  output logic [svsl_pkg::VAL_W-1:0]     value_o,
  output logic [POSITION_BITS-1:0]       ordinal_o
);

  localparam int CMP_W = (POSITION_BITS > svsl_pkg::LEN_W) ? POSITION_BITS : svsl_pkg::LEN_W;
  localparam logic [POSITION_BITS-1:0] CNT_MAX = {POSITION_BITS{1'b1}};

  logic [POSITION_BITS-1:0] ord_q, ord_d;
  logic [POSITION_BITS-1:0] ord_base;
  logic                     accept;
  logic                     out_of_range;

  assign in_i.ready   = push_ready_i;
  assign push_valid_o = in_i.valid;
  assign accept       = in_i.valid && push_ready_i;

  assign out_of_range = (in_i.query_index == '0) ||
                        (CMP_W'(in_i.query_index) > CMP_W'(vector_length_i));

  assign cls_o.is_load       = (in_i.func == svsl_pkg::FUNC_LOAD);
  assign cls_o.restart       = in_i.begin_req;
  assign cls_o.force_missing = in_i.query_missing || out_of_range;

  assign key_o   = cls_o.is_load ? in_i.entry_position : in_i.query_index;
  assign value_o = svsl_pkg::norm_value(in_i.entry_value);

  // The ordinal of a query counts from one in its run and saturates.
  assign ord_base  = in_i.begin_req ? '0 : ord_q;
  assign ord_d     = (ord_base == CNT_MAX) ? ord_base : ord_base + POSITION_BITS'(1);
  assign ordinal_o = ord_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ord_q <= '0;
    end else if (accept && !cls_o.is_load) begin
      ord_q <= ord_d;
    end
  end

endmodule

/* rtl/svsl_queue.sv */
// Two-entry queue that decouples the front end from the search engine.
`timescale 1ns / 1ps
module svsl_queue #(
  parameter int WIDTH = 48
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  logic [WIDTH-1:0] slot_q [2];
  logic             wptr_q, rptr_q;
  logic [1:0]       cnt_q;
  logic             push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_data_o   = slot_q[rptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) begin
        wptr_q <= ~wptr_q;
      end
      if (pop) begin
        rptr_q <= ~rptr_q;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

/* rtl/svsl_back.sv */
// Back end: table memory, binary search engine, hit counter and result register.
`timescale 1ns / 1ps
module svsl_back #(
  parameter int TABLE_DEPTH   = 1024,
  parameter int POSITION_BITS = 21
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        pop_valid_i,
  output logic                        pop_ready_o,
  input  svsl_pkg::cls_t              cls_i,
  input  logic [POSITION_BITS-1:0]    key_i,
  input  logic [svsl_pkg::VAL_W-1:0]  value_i,
  input  logic [POSITION_BITS-1:0]    ordinal_i,
  input  logic [svsl_pkg::VAL_W-1:0]  default_value_i,
  svsl_out_if.source                  res_o
);

  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int WORD_W = POSITION_BITS + svsl_pkg::VAL_W;
  localparam logic [POSITION_BITS-1:0] CNT_MAX = {POSITION_BITS{1'b1}};

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_STEP = 3'b010,
    S_EMIT = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [WORD_W-1:0]          mem_q [TABLE_DEPTH];
  logic [WORD_W-1:0]          rd_q;
  logic                       wr_en;
  logic [ADDR_W-1:0]          wr_addr;
  logic [CNT_W-1:0]           rd_addr;

  logic [CNT_W-1:0]           cnt_q;
  logic [CNT_W-1:0]           lo_q, hi_q, mid_q;
  logic [CNT_W-1:0]           lo_n, hi_n, mid_n;
  logic [POSITION_BITS-1:0]   needle_q;
  logic [POSITION_BITS-1:0]   ord_q;
  logic                       restart_q, forced_q;
  logic                       cand_hit_q, cand_hit_n;
  logic [svsl_pkg::VAL_W-1:0] cand_val_q, cand_val_n;

  logic [POSITION_BITS-1:0]   rd_pos;
  logic [svsl_pkg::VAL_W-1:0] rd_val;
  logic                       lt;
  logic                       pop;
  logic                       out_free, emit_fire;

  logic [POSITION_BITS-1:0]   hits_q, hits_base, hits_new;
  logic                       emit_bit;
  logic [svsl_pkg::VAL_W-1:0] value_res;

  logic                       vld_q;
  logic [svsl_pkg::VAL_W-1:0] res_val_q;
  logic                       res_emit_q;
  logic [POSITION_BITS-1:0]   res_pos_q, res_hits_q;

  assign pop_ready_o = (state_q == S_IDLE);
  assign pop         = pop_valid_i && pop_ready_o;

  // Table memory: one write port for loads, one registered read port for the search.
  assign wr_en   = pop && cls_i.is_load && (cls_i.restart || (cnt_q < CNT_W'(TABLE_DEPTH)));
  assign wr_addr = cls_i.restart ? '0 : cnt_q[ADDR_W-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= {key_i, value_i};
    end
    rd_q <= mem_q[rd_addr[ADDR_W-1:0]];
  end

  assign rd_pos = rd_q[WORD_W-1 -: POSITION_BITS];
  assign rd_val = rd_q[svsl_pkg::VAL_W-1:0];

  // One search step per cycle: the word read at mid_q narrows the interval, and the
  // next midpoint is issued to the memory in the same cycle. Whenever hi moves, the
  // word at the new hi has just been read, so its match is kept as the candidate.
  assign lt         = (rd_pos < needle_q);
  assign lo_n       = lt ? mid_q + CNT_W'(1) : lo_q;
  assign hi_n       = lt ? hi_q : mid_q;
  assign mid_n      = lo_n + ((hi_n - lo_n) >> 1);
  assign cand_hit_n = lt ? cand_hit_q : (rd_pos == needle_q);
  assign cand_val_n = lt ? cand_val_q : rd_val;

  assign rd_addr = (state_q == S_IDLE) ? (cnt_q >> 1) : mid_n;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        // A query that restarts the run still searches the table as loaded.
        if (pop && !cls_i.is_load) begin
          state_d = (cls_i.force_missing || cnt_q == '0) ? S_EMIT : S_STEP;
        end
      end
      S_STEP: begin
        if (lo_n >= hi_n) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (emit_fire) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (wr_en) begin
        cnt_q <= (cls_i.restart ? '0 : cnt_q) + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (pop) begin
          needle_q   <= key_i;
          ord_q      <= ordinal_i;
          restart_q  <= cls_i.restart;
          forced_q   <= cls_i.force_missing;
          lo_q       <= '0;
          hi_q       <= cnt_q;
          mid_q      <= cnt_q >> 1;
          cand_hit_q <= 1'b0;
          cand_val_q <= svsl_pkg::VAL_MISSING;
        end
      end
      S_STEP: begin
        lo_q       <= lo_n;
        hi_q       <= hi_n;
        mid_q      <= mid_n;
        cand_hit_q <= cand_hit_n;
        cand_val_q <= cand_val_n;
      end
      default: begin
      end
    endcase
  end

  // Result and running hit count.
  assign out_free  = !vld_q || res_o.ready;
  assign emit_fire = (state_q == S_EMIT) && out_free;
  assign emit_bit  = forced_q || cand_hit_q;
  assign value_res = forced_q   ? svsl_pkg::VAL_MISSING :
                     cand_hit_q ? cand_val_q : svsl_pkg::norm_value(default_value_i);
  assign hits_base = restart_q ? '0 : hits_q;
  assign hits_new  = (!emit_bit || hits_base == CNT_MAX) ? hits_base
                                                         : hits_base + POSITION_BITS'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hits_q <= '0;
      vld_q  <= 1'b0;
    end else begin
      if (emit_fire) begin
        hits_q <= hits_new;
        vld_q  <= 1'b1;
      end else if (res_o.ready) begin
        vld_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      res_val_q  <= value_res;
      res_emit_q <= emit_bit;
      res_pos_q  <= ord_q;
      res_hits_q <= hits_new;
    end
  end

  assign res_o.valid           = vld_q;
  assign res_o.element_value   = res_val_q;
  assign res_o.emit            = res_emit_q;
  assign res_o.subset_position = res_pos_q;
  assign res_o.hit_count       = res_hits_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(TABLE_DEPTH))
    else $error("entry count exceeds table depth");

  a_step_interval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_STEP) |-> (lo_q < hi_q && mid_q >= lo_q && mid_q < hi_q))
    else $error("search interval is empty or midpoint outside it");

  a_emit_hits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_fire |=> (res_o.valid && (res_o.hit_count == hits_q)))
    else $error("result hit count differs from running count");

endmodule

/* rtl/sparse_vector_subset_lookup_unit.sv */
// Top level of the sparse vector subset lookup unit.
`timescale 1ns / 1ps
// Load items append (position, value) entries to a table of up to TABLE_DEPTH
// entries and leave the search engine free for the next item. A query item
// searches the table in at most s = ceil(log2(n + 1)) search steps for a
// table of n entries (11 steps for 1024); the steps are set by the single
// registered read port of the table memory, one read per step. A query that is
// missing, zero or beyond vector_length, or that finds the table empty, skips
// the search. A two-item queue sits between the input port and the engine, and
// the result register lets the engine search the next item while a result waits.
// Configuration writes are taken at once and must be made while the unit is idle.
module sparse_vector_subset_lookup_unit #(
  parameter int TABLE_DEPTH   = 1024,
  parameter int POSITION_BITS = 21
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  svsl_in_if.sink     in_i,
  svsl_out_if.source  res_o,
  svsl_cfg_if.sink    cfg_i
);

  localparam int QW = svsl_pkg::CLS_W + POSITION_BITS + svsl_pkg::VAL_W + POSITION_BITS;

  logic [svsl_pkg::LEN_W-1:0] vector_length_q;
  logic [svsl_pkg::VAL_W-1:0] default_value_q;

  logic                       push_valid, push_ready;
  svsl_pkg::cls_t             push_cls, pop_cls;
  logic [POSITION_BITS-1:0]   push_key, pop_key;
  logic [svsl_pkg::VAL_W-1:0] push_val, pop_val;
  logic [POSITION_BITS-1:0]   push_ord, pop_ord;
  logic [QW-1:0]              push_data, pop_data;
  logic                       pop_valid, pop_ready;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vector_length_q <= '0;
      default_value_q <= svsl_pkg::VAL_FALSE;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        svsl_pkg::REG_VECTOR_LENGTH: vector_length_q <= cfg_i.data;
        svsl_pkg::REG_DEFAULT_VALUE: default_value_q <= cfg_i.data[svsl_pkg::VAL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  svsl_front #(
    .POSITION_BITS (POSITION_BITS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_i            (in_i),
    .vector_length_i (vector_length_q),
    .push_valid_o    (push_valid),
    .push_ready_i    (push_ready),
    .cls_o           (push_cls),
    .key_o           (push_key),
    .value_o         (push_val),
    .ordinal_o       (push_ord)
  );

  assign push_data = {push_cls, push_key, push_val, push_ord};
  assign {pop_cls, pop_key, pop_val, pop_ord} = pop_data;

  svsl_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  svsl_back #(
    .TABLE_DEPTH   (TABLE_DEPTH),
    .POSITION_BITS (POSITION_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .pop_valid_i     (pop_valid),
    .pop_ready_o     (pop_ready),
    .cls_i           (pop_cls),
    .key_i           (pop_key),
    .value_i         (pop_val),
    .ordinal_i       (pop_ord),
    .default_value_i (default_value_q),
    .res_o           (res_o)
  );

endmodule

/* sim/tb.sv */
// Self-checking testbench of the sparse vector subset lookup unit.
`timescale 1ns / 1ps
module tb;

  localparam int          TABLE_DEPTH   = 1024;
  localparam int unsigned MAX_LEN       = 1048576;
  localparam int unsigned RANDOM_ITEMS  = 500;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned HOLD_CYCLES   = 600;
  localparam int unsigned LIMIT_CYCLES  = 1000000;

  typedef struct packed {
    logic                       func;
    logic                       begin_req;
    logic [svsl_pkg::LEN_W-1:0] entry_position;
    logic [svsl_pkg::VAL_W-1:0] entry_value;
    logic [svsl_pkg::LEN_W-1:0] query_index;
    logic                       query_missing;
  } lookup_req_t;

  typedef struct packed {
    logic [svsl_pkg::VAL_W-1:0] element_value;
    logic                       emit;
    logic [svsl_pkg::LEN_W-1:0] subset_position;
    logic [svsl_pkg::LEN_W-1:0] hit_count;
  } lookup_rsp_t;

  typedef enum int {PACE_NONE, PACE_SEND, PACE_RECV, PACE_BOTH} pace_e;

  // Mirrors the sparse table and the run counters, and keeps the answers still owed.
  class lookup_checker;
    logic [svsl_pkg::LEN_W-1:0] pos_tab [TABLE_DEPTH];
    logic [svsl_pkg::VAL_W-1:0] val_tab [TABLE_DEPTH];
    int unsigned                n_entries;
    logic [svsl_pkg::LEN_W-1:0] run_ordinal;
    logic [svsl_pkg::LEN_W-1:0] run_hits;
    logic [svsl_pkg::LEN_W-1:0] vec_len;
    logic [svsl_pkg::VAL_W-1:0] dflt_val;
    lookup_rsp_t                pending_results[$];
    int unsigned                errors;

    function new();
      n_entries   = 0;
      run_ordinal = '0;
      run_hits    = '0;
      vec_len     = '0;
      dflt_val    = svsl_pkg::VAL_FALSE;
      errors      = 0;
    endfunction

    function logic [svsl_pkg::VAL_W-1:0] fold(input logic [svsl_pkg::VAL_W-1:0] v);
      return (v == svsl_pkg::VAL_UNUSED) ? svsl_pkg::VAL_MISSING : v;
    endfunction

    function logic [svsl_pkg::LEN_W-1:0] bump(input logic [svsl_pkg::LEN_W-1:0] c);
      return (&c) ? c : c + 1'b1;
    endfunction

    function void write_reg(input logic [svsl_pkg::CFG_IDX_W-1:0] idx,
                            input logic [svsl_pkg::LEN_W-1:0] data);
      if (idx == svsl_pkg::REG_VECTOR_LENGTH) begin
        vec_len = data;
      end else begin
        dflt_val = data[svsl_pkg::VAL_W-1:0];
      end
    endfunction

    function void note_item(input lookup_req_t it);
      lookup_rsp_t exp_r;
      int unsigned lo, hi, mid, cnt;
      if (it.func == svsl_pkg::FUNC_LOAD) begin
        if (it.begin_req) n_entries = 0;
        if (n_entries < TABLE_DEPTH) begin
          pos_tab[n_entries] = it.entry_position;
          val_tab[n_entries] = fold(it.entry_value);
          n_entries++;
        end
        return;
      end
      if (it.begin_req) begin
        run_ordinal = '0;
        run_hits    = '0;
      end
      run_ordinal = bump(run_ordinal);
      if (it.query_missing || it.query_index == '0 || it.query_index > vec_len) begin
        exp_r.element_value = svsl_pkg::VAL_MISSING;
        exp_r.emit          = 1'b1;
      end else begin
        // Lower-bound search; only the slot it lands on may match.
        lo  = 0;
        hi  = n_entries;
        cnt = hi;
        while (lo < hi) begin
          mid = lo + (hi - lo) / 2;
          if (pos_tab[mid] < it.query_index) lo = mid + 1;
          else hi = mid;
        end
        if (lo < cnt && pos_tab[lo] == it.query_index) begin
          exp_r.element_value = val_tab[lo];
          exp_r.emit          = 1'b1;
        end else begin
          exp_r.element_value = fold(dflt_val);
          exp_r.emit          = 1'b0;
        end
      end
      if (exp_r.emit) run_hits = bump(run_hits);
      exp_r.subset_position = run_ordinal;
      exp_r.hit_count       = run_hits;
      pending_results.push_back(exp_r);
    endfunction

    function void check_result(input lookup_rsp_t got);
      lookup_rsp_t exp_r;
      if (pending_results.size() == 0) begin
        $error("result with no query outstanding: value %0d emit %0d position %0d hits %0d",
               got.element_value, got.emit, got.subset_position, got.hit_count);
        errors++;
        return;
      end
      exp_r = pending_results.pop_front();
      if (got.element_value !== exp_r.element_value) begin
        $error("element_value: expected %0d, got %0d", exp_r.element_value, got.element_value);
        errors++;
      end
      if (got.emit !== exp_r.emit) begin
        $error("emit: expected %0d, got %0d", exp_r.emit, got.emit);
        errors++;
      end
      if (got.subset_position !== exp_r.subset_position) begin
        $error("subset_position: expected %0d, got %0d",
               exp_r.subset_position, got.subset_position);
        errors++;
      end
      if (got.hit_count !== exp_r.hit_count) begin
        $error("hit_count: expected %0d, got %0d", exp_r.hit_count, got.hit_count);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  svsl_in_if  #(.POSITION_BITS(svsl_pkg::LEN_W)) in_if ();
  svsl_out_if #(.POSITION_BITS(svsl_pkg::LEN_W)) res_if ();
  svsl_cfg_if cfg_if ();

  sparse_vector_subset_lookup_unit #(
    .TABLE_DEPTH  (TABLE_DEPTH),
    .POSITION_BITS(svsl_pkg::LEN_W)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .res_o (res_if),
    .cfg_i (cfg_if)
  );

  lookup_checker              chk;
  pace_e                      pace;
  int unsigned                hold_left;
  int unsigned                sent_items;
  logic [svsl_pkg::LEN_W-1:0] cur_len;
  int unsigned                stim_pos[$];

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin : watchdog
    int unsigned cyc;
    cyc = 0;
    while (cyc < LIMIT_CYCLES) begin
      @(posedge clk);
      cyc++;
    end
    $display("** sparse_vector_subset_lookup_unit: FAILED **");
    $finish;
  end

  // Result side: checks every accepted result and picks the next ready level.
  initial begin : result_sink
    bit stall;
    lookup_rsp_t got;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (res_if.valid && res_if.ready) begin
        got.element_value   = res_if.element_value;
        got.emit            = res_if.emit;
        got.subset_position = res_if.subset_position;
        got.hit_count       = res_if.hit_count;
        chk.check_result(got);
      end
      if (hold_left > 0) begin
        hold_left--;
        stall = 1'b1;
      end else begin
        case (pace)
          PACE_RECV: stall = ($urandom_range(99) < 84);
          PACE_BOTH: stall = ($urandom_range(99) < 6);
          default:   stall = 1'b0;
        endcase
      end
      res_if.ready <= !stall;
    end
  end

  task automatic write_reg(input logic [svsl_pkg::CFG_IDX_W-1:0] idx,
                           input logic [svsl_pkg::LEN_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk); while (!cfg_if.ready);
    chk.write_reg(idx, data);
  endtask

  task automatic set_config(input logic [svsl_pkg::LEN_W-1:0] len,
                            input logic [svsl_pkg::VAL_W-1:0] dflt);
    write_reg(svsl_pkg::REG_VECTOR_LENGTH, len);
    write_reg(svsl_pkg::REG_DEFAULT_VALUE, svsl_pkg::LEN_W'(dflt));
    cfg_if.valid <= 1'b0;
    cur_len = len;
  endtask

  task automatic push_item(input lookup_req_t it);
    int unsigned pct;
    pct = (pace == PACE_SEND) ? 84 : (pace == PACE_BOTH) ? 6 : 0;
    while ($urandom_range(99) < pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid          <= 1'b1;
    in_if.func           <= it.func;
    in_if.begin_req      <= it.begin_req;
    in_if.entry_position <= it.entry_position;
    in_if.entry_value    <= it.entry_value;
    in_if.query_index    <= it.query_index;
    in_if.query_missing  <= it.query_missing;
    do @(posedge clk); while (!in_if.ready);
    chk.note_item(it);
    sent_items++;
  endtask

  // Fields that the function ignores carry random bits.
  task automatic send_load(input bit beg, input logic [svsl_pkg::LEN_W-1:0] pos,
                           input logic [svsl_pkg::VAL_W-1:0] val);
    lookup_req_t it;
    it.func           = svsl_pkg::FUNC_LOAD;
    it.begin_req      = beg;
    it.entry_position = pos;
    it.entry_value    = val;
    it.query_index    = svsl_pkg::LEN_W'($urandom);
    it.query_missing  = $urandom_range(1);
    if (beg) stim_pos.delete();
    if (stim_pos.size() < TABLE_DEPTH) stim_pos.push_back(pos);
    push_item(it);
  endtask

  task automatic send_query(input bit beg, input logic [svsl_pkg::LEN_W-1:0] idx,
                            input bit miss);
    lookup_req_t it;
    it.func           = svsl_pkg::FUNC_QUERY;
    it.begin_req      = beg;
    it.entry_position = svsl_pkg::LEN_W'($urandom);
    it.entry_value    = svsl_pkg::VAL_W'($urandom);
    it.query_index    = idx;
    it.query_missing  = miss;
    push_item(it);
  endtask

  // Waits until every owed result is back and any trailing loads have drained.
  task automatic settle();
    in_if.valid <= 1'b0;
    while (chk.pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_table(input int unsigned count, input int unsigned span,
                            input bit shuffled);
    int unsigned p, stride;
    p = 0;
    stride = (2 * span) / (count + 1);
    if (stride == 0) stride = 1;
    for (int unsigned i = 0; i < count; i++) begin
      if (shuffled) begin
        p = ($urandom_range(9) == 0) ? $urandom_range(2097151) : $urandom_range(span);
      end else begin
        p += $urandom_range(1, stride);
        if (p > MAX_LEN) p = MAX_LEN;
      end
      send_load(i == 0, svsl_pkg::LEN_W'(p), svsl_pkg::VAL_W'($urandom_range(3)));
    end
  endtask

  function automatic logic [svsl_pkg::LEN_W-1:0] pick_index();
    int unsigned r, base;
    r = $urandom_range(99);
    if (r < 40 && stim_pos.size() > 0) begin
      return svsl_pkg::LEN_W'(stim_pos[$urandom_range(stim_pos.size() - 1)]);
    end
    if (r < 55 && stim_pos.size() > 0) begin
      base = stim_pos[$urandom_range(stim_pos.size() - 1)];
      return svsl_pkg::LEN_W'($urandom_range(1) ? base + 1 : base - 1);
    end
    if (r < 63) return '0;
    if (r < 71) return cur_len + svsl_pkg::LEN_W'($urandom_range(1));
    if (r < 80) return svsl_pkg::LEN_W'($urandom_range(2097151));
    return svsl_pkg::LEN_W'($urandom_range(1, (cur_len == '0) ? 1 : cur_len));
  endfunction

  task automatic random_phase();
    int unsigned r, span, n_query;
    logic [svsl_pkg::LEN_W-1:0] len;
    logic [svsl_pkg::VAL_W-1:0] dflt;
    r = $urandom_range(9);
    case (r)
      0:       len = '0;
      1:       len = svsl_pkg::LEN_W'(MAX_LEN);
      2:       len = svsl_pkg::LEN_W'($urandom_range(1, MAX_LEN));
      default: len = svsl_pkg::LEN_W'($urandom_range(1, 4000));
    endcase
    dflt = ($urandom_range(15) == 0) ? svsl_pkg::VAL_UNUSED
                                     : svsl_pkg::VAL_W'($urandom_range(2));
    settle();
    set_config(len, dflt);
    span = (len == '0) ? 4000 : len;
    if ($urandom_range(4) != 0) begin
      load_table(($urandom_range(9) == 0) ? $urandom_range(41, 200) : $urandom_range(0, 40),
                 span, $urandom_range(7) == 0);
    end
    n_query = $urandom_range(10, 60);
    for (int unsigned q = 0; q < n_query; q++) begin
      // An occasional append in the middle of a run may leave the table unsorted.
      if ($urandom_range(49) == 0) begin
        send_load(1'b0, svsl_pkg::LEN_W'($urandom_range(1, span)),
                  svsl_pkg::VAL_W'($urandom_range(3)));
      end
      send_query((q == 0) ? ($urandom_range(4) != 0) : ($urandom_range(32) == 0),
                 pick_index(), $urandom_range(99) < 8);
    end
  endtask

  initial begin : stimulus
    int unsigned p, start, phase;
    chk        = new();
    pace       = PACE_NONE;
    hold_left  = 0;
    sent_items = 0;
    cur_len    = '0;
    rst_n      = 1'b0;
    in_if.valid          = 1'b0;
    in_if.func           = svsl_pkg::FUNC_LOAD;
    in_if.begin_req      = 1'b0;
    in_if.entry_position = '0;
    in_if.entry_value    = svsl_pkg::VAL_FALSE;
    in_if.query_index    = '0;
    in_if.query_missing  = 1'b0;
    res_if.ready         = 1'b0;
    cfg_if.valid         = 1'b0;
    cfg_if.index         = svsl_pkg::REG_VECTOR_LENGTH;
    cfg_if.data          = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty table, extreme positions, code 3, range edges, missing flag.
    set_config(svsl_pkg::LEN_W'(MAX_LEN), svsl_pkg::VAL_TRUE);
    send_query(1'b1, 21'd5, 1'b0);
    send_load(1'b1, 21'd1, svsl_pkg::VAL_FALSE);
    send_load(1'b0, 21'd2, svsl_pkg::VAL_TRUE);
    send_load(1'b0, 21'd1000, svsl_pkg::VAL_UNUSED);
    send_load(1'b0, 21'd600000, svsl_pkg::VAL_TRUE);
    send_load(1'b0, svsl_pkg::LEN_W'(MAX_LEN), svsl_pkg::VAL_MISSING);
    send_query(1'b1, 21'd1, 1'b0);
    send_query(1'b0, 21'd2, 1'b0);
    send_query(1'b0, 21'd1000, 1'b0);
    send_query(1'b0, 21'd600000, 1'b0);
    send_query(1'b0, svsl_pkg::LEN_W'(MAX_LEN), 1'b0);
    send_query(1'b0, 21'd3, 1'b0);
    send_query(1'b0, 21'd0, 1'b0);
    send_query(1'b0, svsl_pkg::LEN_W'(MAX_LEN + 1), 1'b0);
    send_query(1'b0, 21'h1FFFFF, 1'b0);
    send_query(1'b0, 21'd2, 1'b1);
    send_query(1'b1, 21'd1000, 1'b0);
    send_query(1'b0, 21'd999, 1'b0);
    settle();
    set_config('0, svsl_pkg::VAL_MISSING);
    send_query(1'b1, 21'd1, 1'b0);
    send_query(1'b0, 21'd0, 1'b1);
    settle();
    set_config(21'd500, svsl_pkg::VAL_FALSE);
    send_query(1'b0, 21'd1000, 1'b0);
    send_query(1'b0, 21'd2, 1'b0);

    // Full table, with a few loads past the end that must be dropped.
    settle();
    set_config(svsl_pkg::LEN_W'(MAX_LEN), svsl_pkg::VAL_FALSE);
    p = 0;
    for (int unsigned i = 0; i < TABLE_DEPTH + 6; i++) begin
      p += $urandom_range(1, 1900);
      if (p > MAX_LEN) p = MAX_LEN;
      send_load(i == 0, svsl_pkg::LEN_W'(p), svsl_pkg::VAL_W'($urandom_range(3)));
    end
    for (int unsigned q = 0; q < 80; q++) send_query(q == 0, pick_index(), 1'b0);

    start = sent_items;
    phase = 0;
    while (sent_items - start < RANDOM_ITEMS) begin
      pace = pace_e'(phase % 4);
      if (phase == 4) begin
        // Long hold-off on the result side while queries keep coming.
        settle();
        pace = PACE_NONE;
        hold_left = HOLD_CYCLES;
        for (int unsigned q = 0; q < 40; q++) send_query(q == 0, pick_index(), 1'b0);
      end else begin
        random_phase();
      end
      phase++;
    end
    settle();

    if (chk.errors == 0 && chk.pending_results.size() == 0) begin
      $display("** sparse_vector_subset_lookup_unit: PASSED **");
    end else begin
      $display("** sparse_vector_subset_lookup_unit: FAILED **");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/svsl_pkg.sv
rtl/svsl_if.sv
rtl/svsl_front.sv
rtl/svsl_queue.sv
rtl/svsl_back.sv
rtl/sparse_vector_subset_lookup_unit.sv
sim/tb.sv
